// ===== rtl/rossler_rk4_step_assert.svh =====
// Assertion macros for the Rossler RK4 block
`ifndef ROSSLER_RK4_STEP_ASSERT_SVH
`define ROSSLER_RK4_STEP_ASSERT_SVH
// antecedent implies consequent on the next edge
`define RK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// condition holds at every edge
`define RK_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ===== rtl/rk4_pkg.sv =====
`timescale 1ns / 1ps
package rk4_pkg;
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_A  = 3'd0;
	localparam logic [2:0] REG_B  = 3'd1;
	localparam logic [2:0] REG_C  = 3'd2;
	localparam logic [2:0] REG_H  = 3'd3;
	localparam logic [2:0] REG_SX = 3'd4;
	localparam logic [2:0] REG_SY = 3'd5;
	localparam logic [2:0] REG_SZ = 3'd6;

	// (2^32 - 1) / 3, reciprocal used for the divide by 6
	localparam logic signed [31:0] RCP_THIRD = 32'sh5555_5555;

	// Micro-op select for the shared ALU
	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_RCP
	} alu_op_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
		else return v[31:0];
	endfunction
endpackage

// ===== rtl/rk4_if.sv =====
`timescale 1ns / 1ps
interface rk4_in_if;
	logic valid;
	logic ready;
	logic last_step;
	modport source (output valid, output last_step, input ready);
	modport sink (input valid, input last_step, output ready);
endinterface

interface rk4_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] x_value;
	logic [15:0] sample;
	logic burst_end;
	modport source (output valid, output x_value, output sample, output burst_end, input ready);
	modport sink (input valid, input x_value, input sample, input burst_end, output ready);
endinterface

// ===== rtl/rossler_rk4_step.sv =====
`timescale 1ns / 1ps
// Each input beat runs four RK stages on the ALU, then a divide-by-6 and update
// for each of x, y and z; the result beat is valid once the z update is done.
// One beat at a time: no new input beat is taken until the result beat is taken,
// a limit set by the single shared multiply/add unit.
// Async active-low reset clears state, start copies, config and position registers and control.
module rossler_rk4_step #(
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	rk4_in_if.sink      in_ch,
	rk4_out_if.source   out_ch
);
	`include "rossler_rk4_step_assert.svh"

	localparam int UP = FRAC_BITS - 16;

	// config registers
	logic [15:0] a_q, b_q, c_q, h_q, sx_q, sy_q, sz_q;
	logic [15:0] seen_x_q, seen_y_q, seen_z_q;
	logic signed [31:0] px_q, py_q, pz_q;
	// RK accumulators: k1+2k2+2k3+k4, exact (needs 35 bits)
	logic signed [34:0] accx_q, accy_q, accz_q;
	logic signed [31:0] kx_q, ky_q, kz_q;
	logic signed [31:0] t0_q;
	logic [1:0] stg_q;
	logic [4:0] uop_q;
	logic last_q;
	rk4_pkg::state_t st_q, st_d;

	logic signed [31:0] wa, wb, wc, wh;
	assign wa = 32'(a_q) <<< UP;
	assign wb = 32'(b_q) <<< UP;
	assign wc = 32'(c_q) <<< UP;
	assign wh = 32'(h_q) <<< UP;

	// stage offsets: k/2 for stages 1,2; k for stage 3; 0 for stage 0
	logic signed [31:0] ox, oy, oz;
	always_comb begin
		case (stg_q)
			2'd0: begin ox = '0; oy = '0; oz = '0; end
			2'd3: begin ox = kx_q; oy = ky_q; oz = kz_q; end
			default: begin ox = kx_q >>> 1; oy = ky_q >>> 1; oz = kz_q >>> 1; end
		endcase
	end

	// exact sums, saturated when used as a multiplier input
	logic signed [34:0] yz_sum;
	logic signed [34:0] xc_sum;
	assign yz_sum = 35'(py_q) + 35'(oy) + 35'(pz_q) + 35'(oz);
	assign xc_sum = 35'(px_q) + 35'(ox) - 35'(wc);

	rk4_pkg::alu_op_t op;
	logic signed [31:0] opa, opb, alu_q;
	rk4_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .op(op), .opa(opa), .opb(opb), .res_q(alu_q)
	);

	// divide-by-6 operand, quotient
	logic [34:0] dnum_q;
	logic [31:0] dquo_q;
	logic [1:0]  dcnt_q;
	logic dneg_q;
	logic [1:0] dsel_q;
	logic dividing_q;

	// Schedule (uop issues; ALU result on alu_q the cycle after, chained directly):
	// 0 MUL h*sat(yz)        -> 1: kxn = sat(-r)
	// 1 ADD px,ox            -> 2: t0 = xs
	// 2 ADD py,oy            -> 3: ys
	// 3 MUL a,ys             -> 4: a*ys
	// 4 ADD t0,a*ys          -> 5: sum
	// 5 MUL h,sum            -> 6: kyn
	// 6 ADD pz,oz            -> 7: zs
	// 7 MUL zs,sat(xc)       -> 8: zs*xcs
	// 8 ADD wb,zs*xcs        -> 9: sum
	// 9 MUL h,sum            -> 10: kzn, stage done
	// While dividing the ALU runs the reciprocal multiply on the numerator.
	logic signed [31:0] kxn_q, kyn_q;
	always_comb begin
		op = rk4_pkg::OP_ADD; opa = '0; opb = '0;
		if (dividing_q) begin
			op = rk4_pkg::OP_RCP;
			opa = $signed({1'b0, dnum_q[33:3]});
			opb = rk4_pkg::RCP_THIRD;
		end else begin
			case (uop_q)
				5'd0: begin op = rk4_pkg::OP_MUL; opa = wh;
					opb = rk4_pkg::sat32(36'(yz_sum)); end
				5'd1: begin opa = px_q; opb = ox; end
				5'd2: begin opa = py_q; opb = oy; end
				5'd3: begin op = rk4_pkg::OP_MUL; opa = wa; opb = alu_q; end
				5'd4: begin opa = t0_q; opb = alu_q; end
				5'd5: begin op = rk4_pkg::OP_MUL; opa = wh; opb = alu_q; end
				5'd6: begin opa = pz_q; opb = oz; end
				5'd7: begin op = rk4_pkg::OP_MUL; opa = alu_q;
					opb = rk4_pkg::sat32(36'(xc_sum)); end
				5'd8: begin opa = wb; opb = alu_q; end
				5'd9: begin op = rk4_pkg::OP_MUL; opa = wh; opb = alu_q; end
				default: ;
			endcase
		end
	end

	// update: floor(acc/6). Negative acc uses floor(v/6) = -floor((5-v)/6).
	// n/6 = floor((n>>1)/3); estimate from (n>>3)*RCP_THIRD>>30 is at most
	// 2 low, fixed up from the remainder.
	logic [33:0] rcp_rem;
	logic [1:0]  rcp_fix;
	assign rcp_rem = dnum_q[34:1] - ({2'b00, alu_q[31:0]} + {1'b0, alu_q[31:0], 1'b0});
	always_comb begin
		if (rcp_rem >= 34'd6) rcp_fix = 2'd2;
		else if (rcp_rem >= 34'd3) rcp_fix = 2'd1;
		else rcp_fix = 2'd0;
	end

	logic restart;
	assign restart = (sx_q != seen_x_q) || (sy_q != seen_y_q) || (sz_q != seen_z_q);

	logic signed [35:0] qsig;
	always_comb begin
		if (dneg_q) qsig = -36'($signed({1'b0, dquo_q}));
		else qsig = 36'($signed({1'b0, dquo_q}));
	end
	logic signed [31:0] upd_base;
	always_comb begin
		case (dsel_q)
			2'd0: upd_base = px_q;
			2'd1: upd_base = py_q;
			default: upd_base = pz_q;
		endcase
	end
	logic signed [36:0] upd_sum;
	assign upd_sum = 37'(upd_base) + 37'(qsig);
	logic signed [31:0] upd_sat;
	always_comb begin
		if (upd_sum > 37'sh0_7FFF_FFFF) upd_sat = 32'sh7FFF_FFFF;
		else if (upd_sum < -37'sh0_8000_0000) upd_sat = 32'sh8000_0000;
		else upd_sat = upd_sum[31:0];
	end
	logic signed [34:0] dsrc;
	always_comb begin
		case (dsel_q)
			2'd0: dsrc = accx_q;
			2'd1: dsrc = accy_q;
			default: dsrc = accz_q;
		endcase
	end

	logic signed [31:0] kzn;
	assign kzn = alu_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			rk4_pkg::ST_IDLE: if (in_ch.valid) st_d = rk4_pkg::ST_RUN;
			rk4_pkg::ST_RUN: if (dividing_q && dcnt_q == 2'd3 && dsel_q == 2'd2)
				st_d = rk4_pkg::ST_OUT;
			rk4_pkg::ST_OUT: if (out_ch.ready) st_d = rk4_pkg::ST_IDLE;
			default: st_d = rk4_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rk4_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; c_q <= '0; h_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			seen_x_q <= '0; seen_y_q <= '0; seen_z_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			stg_q <= '0; uop_q <= '0; dividing_q <= 1'b0;
			dcnt_q <= '0; dsel_q <= '0; last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rk4_pkg::REG_A:  a_q <= cfg_data;
					rk4_pkg::REG_B:  b_q <= cfg_data;
					rk4_pkg::REG_C:  c_q <= cfg_data;
					rk4_pkg::REG_H:  h_q <= cfg_data;
					rk4_pkg::REG_SX: sx_q <= cfg_data;
					rk4_pkg::REG_SY: sy_q <= cfg_data;
					rk4_pkg::REG_SZ: sz_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == rk4_pkg::ST_IDLE && in_ch.valid) begin
				last_q <= in_ch.last_step;
				stg_q <= '0; uop_q <= '0; dividing_q <= 1'b0;
				if (restart) begin
					seen_x_q <= sx_q; seen_y_q <= sy_q; seen_z_q <= sz_q;
					px_q <= 32'(sx_q) <<< UP;
					py_q <= 32'(sy_q) <<< UP;
					pz_q <= 32'(sz_q) <<< UP;
				end
			end else if (st_q == rk4_pkg::ST_RUN && !dividing_q) begin
				if (uop_q == 5'd10) begin
					uop_q <= '0;
					stg_q <= stg_q + 2'd1;
					if (stg_q == 2'd3) begin
						dividing_q <= 1'b1; dsel_q <= '0; dcnt_q <= '0;
					end
				end else uop_q <= uop_q + 5'd1;
			end else if (st_q == rk4_pkg::ST_RUN) begin
				if (dcnt_q == 2'd3) begin
					dcnt_q <= '0;
					case (dsel_q)
						2'd0: px_q <= upd_sat;
						2'd1: py_q <= upd_sat;
						default: pz_q <= upd_sat;
					endcase
					dsel_q <= dsel_q + 2'd1;
				end else dcnt_q <= dcnt_q + 2'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == rk4_pkg::ST_RUN && !dividing_q) begin
			case (uop_q)
				5'd1: kxn_q <= (alu_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -alu_q;
				5'd2: t0_q <= alu_q;
				5'd6: kyn_q <= alu_q;
				5'd10: begin
					kx_q <= kxn_q; ky_q <= kyn_q; kz_q <= kzn;
					if (stg_q == 2'd0) begin
						accx_q <= 35'(kxn_q); accy_q <= 35'(kyn_q); accz_q <= 35'(kzn);
					end else if (stg_q == 2'd3) begin
						accx_q <= accx_q + 35'(kxn_q);
						accy_q <= accy_q + 35'(kyn_q);
						accz_q <= accz_q + 35'(kzn);
					end else begin
						accx_q <= accx_q + (35'(kxn_q) <<< 1);
						accy_q <= accy_q + (35'(kyn_q) <<< 1);
						accz_q <= accz_q + (35'(kzn) <<< 1);
					end
				end
				default: ;
			endcase
		end
		// divide by 6: load numerator, reciprocal multiply, fix-up, update
		if (st_q == rk4_pkg::ST_RUN && dividing_q) begin
			case (dcnt_q)
				2'd0: begin
					dneg_q <= dsrc[34];
					dnum_q <= dsrc[34] ? 35'(35'sd5 - dsrc) : dsrc;
				end
				2'd2: dquo_q <= alu_q[31:0] + 32'(rcp_fix);
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (st_q == rk4_pkg::ST_IDLE);
	assign out_ch.valid = (st_q == rk4_pkg::ST_OUT);
	assign out_ch.x_value = px_q;
	assign out_ch.sample = px_q[31] ? 16'd0 : 16'(px_q[30:0] >> FRAC_BITS);
	assign out_ch.burst_end = last_q;

	`RK_ASSERT_NEXT(a_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready during run")
	`RK_ASSERT_ALWAYS(a_excl, clk, arst_n, !(in_ch.ready && out_ch.valid), "ready with valid")
	`RK_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, $stable(px_q), "state moved")
endmodule

// ===== rtl/rk4_alu.sv =====
`timescale 1ns / 1ps
// Shared ALU: Q-format multiply with floor shift, saturating add/sub,
// or reciprocal multiply (product >> 30) for the divide by 6.
// Result registered.
module rk4_alu #(
	parameter int FRAC_BITS = 24
) (
	input  logic                 clk,
	input  rk4_pkg::alu_op_t     op,
	input  logic signed [31:0]   opa,
	input  logic signed [31:0]   opb,
	output logic signed [31:0]   res_q
);
	logic signed [63:0] prod;
	logic signed [63:0] shr;
	logic signed [35:0] sum;
	logic signed [31:0] res_d;

	always_comb begin
		prod = opa * opb;
		shr = prod >>> FRAC_BITS;
		sum = 36'(opa) + 36'(opb);
		case (op)
			rk4_pkg::OP_MUL: begin
				if (shr > 64'sh7FFF_FFFF) res_d = 32'sh7FFF_FFFF;
				else if (shr < -64'sh8000_0000) res_d = 32'sh8000_0000;
				else res_d = shr[31:0];
			end
			rk4_pkg::OP_ADD: res_d = rk4_pkg::sat32(36'(opa) + 36'(opb));
			rk4_pkg::OP_SUB: res_d = rk4_pkg::sat32(36'(opa) - 36'(opb));
			// operands are nonnegative here, quotient estimate fits in 31 bits
			rk4_pkg::OP_RCP: res_d = prod[61:30];
			default: res_d = sum[31:0];
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end
endmodule
